// ----- rtl/core/tseu_pkg.sv -----
package tseu_pkg;

    localparam int ID_W      = 6;
    localparam int POS_W     = 12;
    localparam int SPD_W     = 16;
    localparam int CNT_W     = 8;
    localparam int SCALE_W   = 20;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int STAT_W    = 2;

    // shared serial multiplier: signed multiplicand, 16-bit multiplier
    localparam int MCAND_W = 22;
    localparam int MLR_W   = 16;
    localparam int PROD_W  = MCAND_W + MLR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_JITTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMP  = 3'd5;

    localparam logic [SPD_W-1:0]   RST_JITTER    = 16'd179;
    localparam logic [SCALE_W-1:0] RST_SCALE     = 20'd39497;
    localparam logic [SPD_W-1:0]   RST_MIN_SPEED = 16'd6400;
    localparam logic [SPD_W-1:0]   RST_MAX_SPEED = 16'd40960;
    localparam logic [GAIN_W-1:0]  RST_GAIN      = 16'd6554;
    localparam logic [CNT_W-1:0]   RST_MIN_SAMP  = 8'd5;

    localparam logic [STAT_W-1:0] ST_FIRST  = 2'd0;
    localparam logic [STAT_W-1:0] ST_JITTER = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_ACCEPT = 2'd3;

    // 15 km/h in Q8.8, applied once more than three samples were accepted
    localparam logic signed [17:0] SLEW_LIMIT = 18'sd3840;
    localparam logic [CNT_W-1:0]   SLEW_AFTER = 8'd3;

    typedef struct packed {
        logic [ID_W-1:0]  track_id;
        logic [POS_W-1:0] center_x;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SPD_W-1:0]  speed;
        logic              speed_valid;
    } result_t;

    typedef struct packed {
        logic              seen;
        logic [POS_W-1:0]  last_pos;
        logic [SPD_W-1:0]  speed;
        logic [CNT_W-1:0]  count;
    } entry_t;

endpackage

// ----- rtl/core/track_speed_ema_estimator_unit.sv -----
// Per-track speed estimator with a slew-limited moving average.
// Input: start/busy command port carrying item (track_id, center_x); an item
// transfers at a rising edge with start high and busy low.
// Output: done pulses for one cycle with result (status, speed, speed_valid);
// the receiver cannot stall, so the result is simply presented once.
// Configuration: cfg_wr/cfg_index/cfg_data write one register per cycle; write
// only while busy is low.
// Path from the transfer to done: a first or jitter-rejected sample is settled
// in EVAL; an out-of-range sample passes EVAL, MUL1 and RANGE; an accepted
// sample passes EVAL, MUL1, RANGE, SLEW, MUL2 and FIN. Both multiplications run
// bit-serially through one shared shift-add unit. A new item can transfer in the
// cycle where done is high.
// Reset: control and configuration registers return to their reset values, then a
// clearing pass writes every slot of the track store, one per cycle, with busy
// high.
module track_speed_ema_estimator_unit #(
    parameter int TRACKS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tseu_pkg::item_t                   item,
    output logic                              done,
    output tseu_pkg::result_t                 result,
    input  logic                              cfg_wr,
    input  logic [tseu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tseu_pkg::CFG_W-1:0]        cfg_data
);
    import tseu_pkg::*;

    localparam int SLOT_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CMP_W  = (SLOT_W > ID_W) ? SLOT_W + 1 : ID_W + 1;
    localparam logic [CMP_W-1:0]  TRACKS_C  = CMP_W'(TRACKS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TRACKS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_RANGE = 3'd4;
    localparam logic [2:0] S_SLEW  = 3'd5;
    localparam logic [2:0] S_MUL2  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // track_id modulo TRACKS by restoring remainder, one input bit per step
    function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] id);
        logic [CMP_W-1:0] rem;
        rem = '0;
        for (int i = ID_W - 1; i >= 0; i--) begin
            rem = {rem[CMP_W-2:0], id[i]};
            if (rem >= TRACKS_C)
            begin
                rem = rem - TRACKS_C;
            end
        end
        return rem[SLOT_W-1:0];
    endfunction

    entry_t mem [TRACKS];

    logic [2:0]                state_reg, state_next;
    logic [SLOT_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    entry_t                    rd_reg;
    logic [SPD_W-1:0]          v_reg, v_next;
    logic [SPD_W-1:0]          prev_reg, prev_next;
    logic signed [MCAND_W-1:0] mcand_reg, mcand_next;
    logic signed [MCAND_W-1:0] mhi_reg, mhi_next;
    logic [MLR_W-1:0]          mlo_reg, mlo_next;
    logic [3:0]                mcnt_reg, mcnt_next;
    logic                      done_reg, done_next;
    result_t                   result_reg, result_next;

    logic [SPD_W-1:0]   jitter_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SPD_W-1:0]   min_speed_reg;
    logic [SPD_W-1:0]   max_speed_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [CNT_W-1:0]   min_samp_reg;

    logic                accept;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_addr;
    entry_t              mem_wdata;
    entry_t              upd_entry;
    logic [POS_W-1:0]    dx;
    logic                jitter_low;
    logic signed [MCAND_W-1:0] msum;
    logic [PROD_W-1:0]   prod;
    logic [SPD_W-1:0]    v_sat;
    logic [SPD_W-1:0]    prev_sel;
    logic signed [17:0]  v18, prev18, hi18, lo18, vc18, d18;
    logic [39:0]         acc40;
    logic [SPD_W-1:0]    new_speed;
    logic [CNT_W-1:0]    count_inc;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign dx = (pos_reg >= rd_reg.last_pos) ? pos_reg - rd_reg.last_pos
                                             : rd_reg.last_pos - pos_reg;
    assign jitter_low = {dx, 8'h00} < 20'(jitter_reg);

    assign msum = mhi_reg + (mlo_reg[0] ? mcand_reg : '0);
    assign prod = {mhi_reg, mlo_reg};
    assign v_sat = (prod[PROD_W-1:SPD_W] != '0) ? '1 : prod[SPD_W-1:0];

    assign prev_sel = (rd_reg.count == '0) ? v_reg : rd_reg.speed;
    assign v18    = $signed({2'b00, v_reg});
    assign prev18 = $signed({2'b00, prev_sel});
    assign hi18   = prev18 + SLEW_LIMIT;
    assign lo18   = prev18 - SLEW_LIMIT;

    always_comb
    begin
        vc18 = v18;
        if (rd_reg.count > SLEW_AFTER)
        begin
            if (vc18 > hi18)
            begin
                vc18 = hi18;
            end
            if (vc18 < lo18)
            begin
                vc18 = lo18;
            end
        end
    end

    assign d18 = vc18 - prev18;

    // prev * 2^16 + gain * (v - prev), rounded half up
    assign acc40 = {8'h00, prev_reg, 16'h0000} + 40'd32768
                 + {{(40 - PROD_W){prod[PROD_W-1]}}, prod};
    assign new_speed = acc40[31:16];
    assign count_inc = (rd_reg.count == '1) ? rd_reg.count : rd_reg.count + 8'd1;

    always_comb
    begin
        upd_entry          = rd_reg;
        upd_entry.seen     = 1'b1;
        upd_entry.last_pos = pos_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        prev_next    = prev_reg;
        mcand_next   = mcand_reg;
        mhi_next     = mhi_reg;
        mlo_next     = mlo_reg;
        mcnt_next    = mcnt_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_we       = 1'b0;
        mem_addr     = slot_reg;
        mem_wdata    = upd_entry;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    slot_next  = slot_of(item.track_id);
                    pos_next   = item.center_x;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!rd_reg.seen || jitter_low)
                begin
                    mem_we                  = 1'b1;
                    done_next               = 1'b1;
                    result_next.status      = rd_reg.seen ? ST_JITTER : ST_FIRST;
                    result_next.speed       = rd_reg.speed;
                    result_next.speed_valid = rd_reg.count >= min_samp_reg;
                    state_next              = S_IDLE;
                end
                else
                begin
                    mcand_next = MCAND_W'(scale_reg);
                    mhi_next   = '0;
                    mlo_next   = MLR_W'(dx);
                    mcnt_next  = 4'hF;
                    state_next = S_MUL1;
                end
            end
            S_MUL1, S_MUL2:
            begin
                // add partial product, shift the pair right one bit
                mhi_next  = msum >>> 1;
                mlo_next  = {msum[0], mlo_reg[MLR_W-1:1]};
                mcnt_next = mcnt_reg - 4'd1;
                if (mcnt_reg == 4'd0)
                begin
                    state_next = (state_reg == S_MUL1) ? S_RANGE : S_FIN;
                end
            end
            S_RANGE:
            begin
                v_next = v_sat;
                if (v_sat < min_speed_reg || v_sat > max_speed_reg)
                begin
                    mem_we                  = 1'b1;
                    done_next               = 1'b1;
                    result_next.status      = ST_RANGE;
                    result_next.speed       = rd_reg.speed;
                    result_next.speed_valid = rd_reg.count >= min_samp_reg;
                    state_next              = S_IDLE;
                end
                else
                begin
                    state_next = S_SLEW;
                end
            end
            S_SLEW:
            begin
                prev_next  = prev_sel;
                mcand_next = {{(MCAND_W - 18){d18[17]}}, d18};
                mhi_next   = '0;
                mlo_next   = gain_reg;
                mcnt_next  = 4'hF;
                state_next = S_MUL2;
            end
            S_FIN:
            begin
                mem_we                  = 1'b1;
                mem_wdata.speed         = new_speed;
                mem_wdata.count         = count_inc;
                done_next               = 1'b1;
                result_next.status      = ST_ACCEPT;
                result_next.speed       = new_speed;
                result_next.speed_valid = count_inc >= min_samp_reg;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_reg <= mem[slot_of(item.track_id)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            mcnt_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            mcnt_reg    <= mcnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        pos_reg    <= pos_next;
        v_reg      <= v_next;
        prev_reg   <= prev_next;
        mcand_reg  <= mcand_next;
        mhi_reg    <= mhi_next;
        mlo_reg    <= mlo_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jitter_reg    <= RST_JITTER;
            scale_reg     <= RST_SCALE;
            min_speed_reg <= RST_MIN_SPEED;
            max_speed_reg <= RST_MAX_SPEED;
            gain_reg      <= RST_GAIN;
            min_samp_reg  <= RST_MIN_SAMP;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_JITTER:    jitter_reg    <= cfg_data[SPD_W-1:0];
                CFG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                CFG_MIN_SPEED: min_speed_reg <= cfg_data[SPD_W-1:0];
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[SPD_W-1:0];
                CFG_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                CFG_MIN_SAMP:  min_samp_reg  <= cfg_data[CNT_W-1:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/tseu_chk.sv -----
module tseu_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input tseu_pkg::result_t result
);
    import tseu_pkg::*;

    // a transfer always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after a transfer");

    // a result only appears as the block goes idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // no result in the cycle right after a transfer
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !done)
        else $error("result too early after transfer");

    // idle without a transfer produces nothing
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !done)
        else $error("result without a transfer");

    // a first sample leaves the speed untouched, so it is still zero from the clearing pass
    a_first_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FIRST |-> result.speed == '0)
        else $error("first sample with nonzero speed");

endmodule

bind track_speed_ema_estimator_unit tseu_chk u_tseu_chk (.*);
